@@ src/sogi_phase_locked_loop_assert.svh @@
// ----------------------------------------------------------------------------
// SOGI PLL assertion macros
// Shared property shapes for the phase-locked loop's own checks.
// ----------------------------------------------------------------------------
`ifndef SOGI_PHASE_LOCKED_LOOP_ASSERT_SVH
`define SOGI_PHASE_LOCKED_LOOP_ASSERT_SVH

// Condition in one cycle implies a result in the next cycle.
`define SOGI_ASSERT_NEXT(label, cond, res) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (res)) \
        else $error("sogi pll check failed");

// Condition implies a result in the same cycle.
`define SOGI_ASSERT_NOW(label, cond, res) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (res)) \
        else $error("sogi pll check failed");

`endif

@@ src/sogi_pll_pkg.sv @@
// ----------------------------------------------------------------------------
// SOGI PLL package
// Sequencer steps and configuration register indexes.
// ----------------------------------------------------------------------------
package sogi_pll_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INUM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QNUM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QDEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE, S_BA1, S_BA2, S_BB1, S_BB2, S_BB0, S_BY, S_BFIN,
        S_PD1, S_PD2, S_PQ1, S_PQ2, S_PQ3, S_PQF,
        S_KI, S_KP, S_FRQ, S_FSUM, S_FSAT,
        S_PH1, S_PH2, S_PH3, S_PH4, S_TAB, S_OUT
    } t_step;

endpackage

@@ src/sogi_phase_locked_loop.sv @@
// ----------------------------------------------------------------------------
// SOGI phase-locked loop
// Single-phase grid PLL built around one shared multiplier and a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on i_valid / o_ready with i_grid_sample. One beat carries
//   one sample, and each sample yields exactly one result beat on
//   o_valid / i_ready carrying phase, sine, cosine, d, q, frequency, alpha
//   and beta.
//   Configuration is written on i_cfg_valid / o_cfg_ready with a register
//   index and data; o_cfg_ready is always high. Write only while idle.
//   A new sample is taken only when idle, after the previous result has been
//   loaded into the output register. The time per sample is set by the
//   single shared multiplier: every product of both biquads, the Park
//   transform, the PI regulator and the phase update passes through it in
//   turn, followed by a sine/cosine ROM read.
//   Results sit in an output register; if the receiver stalls, the finished
//   result waits there and the next sample's computation runs up to its
//   final step, which holds until the register is free.
//   Reset (synchronous, active low) clears the control and configuration
//   registers, filter states, integrator, phase and the stored sine/cosine.
// ----------------------------------------------------------------------------
module sogi_phase_locked_loop #(
    parameter int SAMPLE_BITS      = 16,
    parameter int COEF_BITS        = 16,
    parameter int TRIG_TABLE_DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sogi_pll_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [3*COEF_BITS-1:0]               i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_grid_sample,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [15:0]                          o_phase_angle,
    output logic signed [SAMPLE_BITS-1:0]        o_phase_sine,
    output logic signed [SAMPLE_BITS-1:0]        o_phase_cosine,
    output logic signed [SAMPLE_BITS-1:0]        o_direct_part,
    output logic signed [SAMPLE_BITS-1:0]        o_quadrature_part,
    output logic signed [31:0]                   o_frequency_term,
    output logic signed [SAMPLE_BITS-1:0]        o_alpha_signal,
    output logic signed [SAMPLE_BITS-1:0]        o_beta_signal
);
    import sogi_pll_pkg::*;

    localparam int SIG_FRAC  = SAMPLE_BITS - 1;
    localparam int CO_FRAC   = COEF_BITS - 2;
    localparam int A_W0      = (COEF_BITS > SAMPLE_BITS + 1) ? COEF_BITS : SAMPLE_BITS + 1;
    localparam int A_W       = (A_W0 > 17) ? A_W0 : 17;
    localparam int B_W       = 33;
    localparam int P_W       = A_W + B_W;
    localparam int ACC_W     = P_W + 3;
    localparam int TAB_IDX_W = $clog2(TRIG_TABLE_DEPTH);
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor term divisors (2n)(2n+1) for sine and (2n-1)(2n) for cosine.
    localparam longint unsigned SIN_DIV [9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                64'd156, 64'd210, 64'd272, 64'd342};
    localparam longint unsigned COS_DIV [9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                64'd132, 64'd182, 64'd240, 64'd306};

    typedef logic signed [SAMPLE_BITS-1:0] t_tab [TRIG_TABLE_DEPTH];

    localparam logic signed [ACC_W-1:0] L_ONE   = signed'(ACC_W'(1));
    localparam logic signed [ACC_W-1:0] L_MAX32 = (L_ONE <<< 31) - L_ONE;
    localparam logic signed [ACC_W-1:0] L_MIN32 = -L_MAX32 - L_ONE;
    localparam logic signed [ACC_W-1:0] L_SMAX  = (L_ONE <<< (SAMPLE_BITS - 1)) - L_ONE;
    localparam logic signed [ACC_W-1:0] L_SMIN  = -L_SMAX - L_ONE;

    // Rounds a Q30 magnitude to the signal format, clamped to the largest code.
    function automatic logic signed [SAMPLE_BITS-1:0] q30_to_sig(
        input longint unsigned mag, input logic neg);
        longint unsigned r;
        longint unsigned hi;
        r  = (mag + (64'd1 << (30 - SIG_FRAC - 1))) >> (30 - SIG_FRAC);
        hi = (64'd1 << SIG_FRAC) - 64'd1;
        if (r > hi) begin
            r = hi;
        end
        return neg ? -SAMPLE_BITS'(r) : SAMPLE_BITS'(r);
    endfunction

    // Quarter-wave Taylor series in Q30, folded out to a full turn.
    function automatic t_tab build_tab(input logic sel_cos);
        t_tab t;
        longint unsigned quarter, rem, x, x2, st, ct;
        longint s, c;
        for (int i = 0; i < TRIG_TABLE_DEPTH; i++) begin
            quarter = (64'd4 * i) / TRIG_TABLE_DEPTH;
            rem     = (64'd4 * i) % TRIG_TABLE_DEPTH;
            x       = HALF_PI_Q30 * rem / TRIG_TABLE_DEPTH;
            x2      = (x * x) >> 30;
            st      = x;
            ct      = 64'd1 << 30;
            s       = longint'(x);
            c       = longint'(ct);
            for (int n = 1; n <= 9; n++) begin
                st = ((st * x2) >> 30) / SIN_DIV[n - 1];
                ct = ((ct * x2) >> 30) / COS_DIV[n - 1];
                if (n % 2 == 1) begin
                    s = s - longint'(st);
                    c = c - longint'(ct);
                end else begin
                    s = s + longint'(st);
                    c = c + longint'(ct);
                end
            end
            if (s < 0) s = 0;
            if (c < 0) c = 0;
            case (quarter)
                64'd0: t[i] = sel_cos ? q30_to_sig(c, 1'b0) : q30_to_sig(s, 1'b0);
                64'd1: t[i] = sel_cos ? q30_to_sig(s, 1'b1) : q30_to_sig(c, 1'b0);
                64'd2: t[i] = sel_cos ? q30_to_sig(c, 1'b1) : q30_to_sig(s, 1'b1);
                default: t[i] = sel_cos ? q30_to_sig(s, 1'b0) : q30_to_sig(c, 1'b1);
            endcase
        end
        return t;
    endfunction

    localparam t_tab C_SIN = build_tab(1'b0);
    localparam t_tab C_COS = build_tab(1'b1);

    function automatic logic signed [ACC_W-1:0] rnd(
        input logic signed [ACC_W-1:0] v, input int sh);
        return (v + (L_ONE <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > L_MAX32) return L_MAX32[31:0];
        if (v < L_MIN32) return L_MIN32[31:0];
        return v[31:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sats(input logic signed [ACC_W-1:0] v);
        if (v > L_SMAX) return L_SMAX[SAMPLE_BITS-1:0];
        if (v < L_SMIN) return L_SMIN[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Configuration registers
    logic [3*COEF_BITS-1:0] r_inum, r_qnum;
    logic [2*COEF_BITS-1:0] r_iden, r_qden;
    logic [30:0]            r_kp, r_ki;
    logic [31:0]            r_step_size;

    // Loop state
    logic signed [31:0]            r_id1, r_id2, r_qd1, r_qd2, r_integral;
    logic [31:0]                   r_phase;
    logic signed [SAMPLE_BITS-1:0] r_last_sin, r_last_cos;

    // Control
    t_step r_step, n_step;
    logic  r_ch;
    logic  r_ovalid;

    // Datapath
    logic signed [SAMPLE_BITS-1:0] r_x, r_alpha, r_beta, r_d, r_q;
    logic signed [31:0]            r_w0, r_freq;
    logic signed [32:0]            r_f;
    logic signed [P_W-1:0]         r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic signed [A_W-1:0]   m_a;
    logic signed [B_W-1:0]   m_b;
    logic [3*COEF_BITS-1:0]  num;
    logic [2*COEF_BITS-1:0]  den;
    logic signed [31:0]      w1, w2;
    logic signed [ACC_W-1:0] pext;
    logic signed [SAMPLE_BITS:0] diff;
    logic                    load_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_step == S_IDLE);
    assign o_valid     = r_ovalid;

    assign num  = r_ch ? r_qnum : r_inum;
    assign den  = r_ch ? r_qden : r_iden;
    assign w1   = r_ch ? r_qd1 : r_id1;
    assign w2   = r_ch ? r_qd2 : r_id2;
    assign pext = ACC_W'(r_prod);
    assign diff = -((SAMPLE_BITS + 1)'(r_q));
    assign load_out = (r_step == S_OUT) && (!r_ovalid || i_ready);

    // Next step and multiplier operand selection
    always_comb begin
        n_step = r_step;
        m_a    = '0;
        m_b    = '0;
        case (r_step)
            S_IDLE: if (i_valid) n_step = S_BA1;
            S_BA1: begin
                m_a = A_W'(signed'(den[COEF_BITS-1:0]));
                m_b = B_W'(w1);
                n_step = S_BA2;
            end
            S_BA2: begin
                m_a = A_W'(signed'(den[2*COEF_BITS-1:COEF_BITS]));
                m_b = B_W'(w2);
                n_step = S_BB1;
            end
            S_BB1: begin
                m_a = A_W'(signed'(num[2*COEF_BITS-1:COEF_BITS]));
                m_b = B_W'(w1);
                n_step = S_BB2;
            end
            S_BB2: begin
                m_a = A_W'(signed'(num[3*COEF_BITS-1:2*COEF_BITS]));
                m_b = B_W'(w2);
                n_step = S_BB0;
            end
            S_BB0: begin
                m_a = A_W'(signed'(num[COEF_BITS-1:0]));
                m_b = B_W'(r_w0);
                n_step = S_BY;
            end
            S_BY:   n_step = S_BFIN;
            S_BFIN: n_step = r_ch ? S_PD1 : S_BA1;
            S_PD1: begin
                m_a = A_W'(r_alpha);
                m_b = B_W'(r_last_cos);
                n_step = S_PD2;
            end
            S_PD2: begin
                m_a = A_W'(r_beta);
                m_b = B_W'(r_last_sin);
                n_step = S_PQ1;
            end
            S_PQ1: begin
                m_a = A_W'(r_beta);
                m_b = B_W'(r_last_cos);
                n_step = S_PQ2;
            end
            S_PQ2: begin
                m_a = A_W'(r_alpha);
                m_b = B_W'(r_last_sin);
                n_step = S_PQ3;
            end
            S_PQ3:  n_step = S_PQF;
            S_PQF:  n_step = S_KI;
            S_KI: begin
                m_a = A_W'(diff);
                m_b = signed'(B_W'(r_ki));
                n_step = S_KP;
            end
            S_KP: begin
                m_a = A_W'(diff);
                m_b = signed'(B_W'(r_kp));
                n_step = S_FRQ;
            end
            S_FRQ:  n_step = S_FSUM;
            S_FSUM: n_step = S_FSAT;
            S_FSAT: n_step = S_PH1;
            S_PH1: begin
                m_a = signed'(A_W'(r_f[15:0]));
                m_b = signed'(B_W'(r_step_size));
                n_step = S_PH2;
            end
            S_PH2: begin
                m_a = A_W'(signed'(r_f[32:16]));
                m_b = signed'(B_W'(r_step_size));
                n_step = S_PH3;
            end
            S_PH3:  n_step = S_PH4;
            S_PH4:  n_step = S_TAB;
            S_TAB:  n_step = S_OUT;
            S_OUT:  if (load_out) n_step = S_IDLE;
            default: n_step = S_IDLE;
        endcase
    end

    // Control, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_ch        <= 1'b0;
            r_ovalid    <= 1'b0;
            r_inum      <= '0;
            r_iden      <= '0;
            r_qnum      <= '0;
            r_qden      <= '0;
            r_kp        <= '0;
            r_ki        <= '0;
            r_step_size <= '0;
            r_id1       <= '0;
            r_id2       <= '0;
            r_qd1       <= '0;
            r_qd2       <= '0;
            r_integral  <= '0;
            r_phase     <= '0;
            r_last_sin  <= '0;
            r_last_cos  <= '0;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INUM: r_inum      <= i_cfg_data;
                    CFG_IDEN: r_iden      <= i_cfg_data[2*COEF_BITS-1:0];
                    CFG_QNUM: r_qnum      <= i_cfg_data;
                    CFG_QDEN: r_qden      <= i_cfg_data[2*COEF_BITS-1:0];
                    CFG_KP:   r_kp        <= i_cfg_data[30:0];
                    CFG_KI:   r_ki        <= i_cfg_data[30:0];
                    CFG_STEP: r_step_size <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_step)
                S_IDLE: r_ch <= 1'b0;
                S_BFIN: begin
                    r_ch <= 1'b1;
                    if (r_ch) begin
                        r_qd2 <= r_qd1;
                        r_qd1 <= r_w0;
                    end else begin
                        r_id2 <= r_id1;
                        r_id1 <= r_w0;
                    end
                end
                S_FRQ: r_integral <= sat32(r_acc);
                S_PH4: r_phase    <= r_phase - r_acc[31:0];
                S_TAB: begin
                    r_last_sin <= C_SIN[r_phase[31 -: TAB_IDX_W]];
                    r_last_cos <= C_COS[r_phase[31 -: TAB_IDX_W]];
                end
                default: ;
            endcase
        end
    end

    // Shared multiplier, accumulator and working registers
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        case (r_step)
            S_IDLE: if (i_valid) r_x <= i_grid_sample;
            S_BA1:  r_acc <= ACC_W'(r_x);
            S_BA2:  r_acc <= r_acc - rnd(pext, CO_FRAC);
            S_BB1:  r_acc <= r_acc - rnd(pext, CO_FRAC);
            S_BB2: begin
                r_w0  <= sat32(r_acc);
                r_acc <= pext;
            end
            S_BB0:  r_acc <= r_acc + pext;
            S_BY:   r_acc <= r_acc + pext;
            S_BFIN: begin
                if (r_ch) r_beta  <= sats(rnd(r_acc, CO_FRAC));
                else      r_alpha <= sats(rnd(r_acc, CO_FRAC));
            end
            S_PD2:  r_acc <= pext;
            S_PQ1:  r_acc <= r_acc + pext;
            S_PQ2: begin
                r_d   <= sats(rnd(r_acc, SIG_FRAC));
                r_acc <= pext;
            end
            S_PQ3:  r_acc <= r_acc - pext;
            S_PQF:  r_q   <= sats(rnd(r_acc, SIG_FRAC));
            S_KP:   r_acc <= ACC_W'(r_integral) + rnd(pext, SIG_FRAC);
            S_FRQ:  r_acc <= rnd(pext, SIG_FRAC);
            S_FSUM: r_acc <= r_acc + ACC_W'(r_integral);
            S_FSAT: begin
                r_freq <= sat32(r_acc);
                r_f    <= 33'(sat32(r_acc)) + 33'sd32768;
            end
            S_PH2:  r_acc <= ACC_W'(r_prod >>> 16);
            S_PH3:  r_acc <= r_acc + pext;
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_phase_angle     <= r_phase[31:16];
            o_phase_sine      <= r_last_sin;
            o_phase_cosine    <= r_last_cos;
            o_direct_part     <= r_d;
            o_quadrature_part <= r_q;
            o_frequency_term  <= r_freq;
            o_alpha_signal    <= r_alpha;
            o_beta_signal     <= r_beta;
        end
    end

`include "sogi_phase_locked_loop_assert.svh"

    // A taken sample always starts the in-phase biquad on channel zero.
    `SOGI_ASSERT_NEXT(a_start, (i_valid && o_ready), (r_step == S_BA1 && !r_ch))
    // A held result is never overwritten by the next sample's result.
    `SOGI_ASSERT_NEXT(a_hold, (r_step == S_OUT && r_ovalid && !i_ready), (r_step == S_OUT))
    // The phase moves only in its update step.
    `SOGI_ASSERT_NEXT(a_phase, (r_step != S_PH4), $stable(r_phase))
    // The Park transform runs only after both biquads have finished.
    `SOGI_ASSERT_NOW(a_park, (r_step == S_PD1), r_ch)

endmodule
